/* sv/pair_barrier_force_top_assert.svh */
// Assertion macros used by the port-level checker.
`ifndef PAIR_BARRIER_FORCE_TOP_ASSERT_SVH
`define PAIR_BARRIER_FORCE_TOP_ASSERT_SVH
// Combinational invariant, sampled every clock outside reset.
`define PBF_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("pbf invariant violated");
// Implication whose consequent is checked in the next cycle.
`define PBF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pbf sequence violated");
`endif

/* sv/pbf_pkg.sv */
// Shared types, constants and helper functions of the pair barrier force block.
package pbf_pkg;
	localparam int DIST_W    = 31;
	localparam int DIR_W     = 32;
	localparam int VEL_W     = 32;
	localparam int MASS_W    = 31;
	localparam int ACC_W     = 32;
	localparam int CFG_W     = 31;
	localparam int CFG_IDX_W = 2;
	localparam int FAC_W     = 47;
	localparam int DIVD_W    = FAC_W + 16;
	localparam int Q_W       = DIVD_W + 1;
	localparam int R_W       = 34;

	localparam logic [1:0] KIND_FF   = 2'd0;
	localparam logic [1:0] KIND_FB   = 2'd1;
	localparam logic [1:0] KIND_BF   = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_BARRIER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STIFF   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DAMP    = 2'd2;

	localparam logic [CFG_W-1:0] BARRIER_RST = 31'd65536;
	localparam logic [CFG_W-1:0] STIFF_RST   = 31'd65536;
	localparam logic [CFG_W-1:0] DAMP_RST    = 31'd0;

	localparam logic signed [DIR_W-1:0] ONE_Q30       = 32'sh4000_0000;
	localparam logic signed [DIR_W-1:0] MINUS_ONE_Q30 = 32'shC000_0000;

	typedef struct packed {
		logic [1:0]             kind;
		logic                   fown;
		logic                   pown;
		logic                   active;
		logic                   sat;
		logic                   negfac;
		logic                   nega;
		logic                   fac_zero;
		logic                   ma_zero;
		logic                   mb_zero;
		logic [2:0][DIR_W-1:0]  e;
	} pbf_side_t;

	typedef struct packed {
		logic [2:0][ACC_W-1:0] acc_a;
		logic [2:0][ACC_W-1:0] acc_b;
		logic                  apply_a;
		logic                  apply_b;
		logic                  sat;
	} pbf_res_t;

	function automatic logic [DIR_W-1:0] clamp_dir(input logic [DIR_W-1:0] v);
		logic [DIR_W-1:0] r;
		r = v;
		if ($signed(v) > ONE_Q30)
			r = ONE_Q30;
		else if ($signed(v) < MINUS_ONE_Q30)
			r = MINUS_ONE_Q30;
		return r;
	endfunction

	// {clip flag, signed saturated component}
	function automatic logic [ACC_W:0] comp_fn(input logic [R_W-1:0] r, input logic neg);
		logic             sat;
		logic [ACC_W-1:0] val;
		sat = 1'b0;
		val = '0;
		if (r == '0)
			val = '0;
		else if (neg) begin
			if (r > 34'h0_8000_0000) begin
				sat = 1'b1;
				val = 32'h8000_0000;
			end else
				val = ACC_W'(34'd0 - r);
		end else begin
			if (r > 34'h0_7FFF_FFFF) begin
				sat = 1'b1;
				val = 32'h7FFF_FFFF;
			end else
				val = r[ACC_W-1:0];
		end
		return {sat, val};
	endfunction
endpackage

/* sv/pbf_ifs.sv */
// Valid/ready channel interfaces for pairs in and forces out.
interface pbf_in_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  pair_kind;
	logic                        fluid_owned;
	logic                        partner_owned;
	logic [pbf_pkg::DIST_W-1:0]  pair_distance;
	logic [pbf_pkg::DIR_W-1:0]   dir_x;
	logic [pbf_pkg::DIR_W-1:0]   dir_y;
	logic [pbf_pkg::DIR_W-1:0]   dir_z;
	logic [pbf_pkg::VEL_W-1:0]   relvel_x;
	logic [pbf_pkg::VEL_W-1:0]   relvel_y;
	logic [pbf_pkg::VEL_W-1:0]   relvel_z;
	logic [pbf_pkg::MASS_W-1:0]  mass_first;
	logic [pbf_pkg::MASS_W-1:0]  mass_second;
	modport source(output valid, pair_kind, fluid_owned, partner_owned, pair_distance,
		dir_x, dir_y, dir_z, relvel_x, relvel_y, relvel_z, mass_first, mass_second,
		input ready);
	modport sink(input valid, pair_kind, fluid_owned, partner_owned, pair_distance,
		dir_x, dir_y, dir_z, relvel_x, relvel_y, relvel_z, mass_first, mass_second,
		output ready);
endinterface

interface pbf_out_if;
	logic                       valid;
	logic                       ready;
	logic [pbf_pkg::ACC_W-1:0]  accel_a_x;
	logic [pbf_pkg::ACC_W-1:0]  accel_a_y;
	logic [pbf_pkg::ACC_W-1:0]  accel_a_z;
	logic [pbf_pkg::ACC_W-1:0]  accel_b_x;
	logic [pbf_pkg::ACC_W-1:0]  accel_b_y;
	logic [pbf_pkg::ACC_W-1:0]  accel_b_z;
	logic                       apply_a;
	logic                       apply_b;
	logic                       saturated;
	modport source(output valid, accel_a_x, accel_a_y, accel_a_z, accel_b_x, accel_b_y,
		accel_b_z, apply_a, apply_b, saturated, input ready);
	modport sink(input valid, accel_a_x, accel_a_y, accel_a_z, accel_b_x, accel_b_y,
		accel_b_z, apply_a, apply_b, saturated, output ready);
endinterface

/* sv/pbf_front.sv */
// Front pipeline: clamp, dot product, spring and damper terms, force clip (7 stages).
module pbf_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	pbf_in_if.sink                       pair_in,
	input  logic [pbf_pkg::CFG_W-1:0]    barrier_distance,
	input  logic [pbf_pkg::CFG_W-1:0]    stiffness,
	input  logic [pbf_pkg::CFG_W-1:0]    damping,
	output logic                         v_o,
	output logic [pbf_pkg::FAC_W-1:0]    facmag_o,
	output logic [pbf_pkg::MASS_W-1:0]   mass_a_o,
	output logic [pbf_pkg::MASS_W-1:0]   mass_b_o,
	output pbf_pkg::pbf_side_t           side_o
);
	typedef struct packed {
		logic [1:0]                     kind;
		logic                           fown;
		logic                           pown;
		logic                           active;
		logic [2:0][pbf_pkg::DIR_W-1:0] e;
		logic [pbf_pkg::MASS_W-1:0]     ma;
		logic [pbf_pkg::MASS_W-1:0]     mb;
	} carry_t;

	logic [7:1] v_s;
	carry_t c_s1, c_s2, c_s3, c_s4, c_s5, c_s6;
	logic [2:0][pbf_pkg::VEL_W-1:0] rv_s1;
	logic [pbf_pkg::DIST_W-1:0]     g_s1;
	logic signed [63:0]             pv_s2 [0:2];
	logic [61:0]                    p1_s2, p2_s2;
	logic signed [63:0]             sum_s3;
	logic [45:0]                    t1_s3, t1_s4, t1_s5, t1_s6;
	logic [45:0]                    dg_s3, dg_s4;
	logic                           vneg_s4, vneg_s5, vneg_s6;
	logic [pbf_pkg::R_W-1:0]        vn_s4;
	logic [56:0]                    pl_s5, ph_s5;
	logic [48:0]                    t2_s6;
	logic                           sat_s6;

	logic [63:0]                    smag;
	logic [79:0]                    prod;
	logic signed [50:0]             fac;
	logic signed [50:0]             fac_c;
	logic                           fac_clip;
	logic [pbf_pkg::FAC_W-1:0]      fmag;
	logic                           fneg;
	logic [pbf_pkg::MASS_W-1:0]     msel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (en)
			v_s <= {v_s[6:1], pair_in.valid};
	end

	// s1: capture, clamp direction, activity test, gap
	always_ff @(posedge clk) begin
		if (en) begin
			c_s1.kind   <= pair_in.pair_kind;
			c_s1.fown   <= pair_in.fluid_owned;
			c_s1.pown   <= pair_in.partner_owned;
			c_s1.active <= (pair_in.pair_kind != pbf_pkg::KIND_NONE) &&
				(pair_in.pair_distance < barrier_distance);
			c_s1.e[0]   <= pbf_pkg::clamp_dir(pair_in.dir_x);
			c_s1.e[1]   <= pbf_pkg::clamp_dir(pair_in.dir_y);
			c_s1.e[2]   <= pbf_pkg::clamp_dir(pair_in.dir_z);
			c_s1.ma     <= pair_in.mass_first;
			c_s1.mb     <= pair_in.mass_second;
			rv_s1[0]    <= pair_in.relvel_x;
			rv_s1[1]    <= pair_in.relvel_y;
			rv_s1[2]    <= pair_in.relvel_z;
			g_s1        <= barrier_distance - pair_in.pair_distance;
		end
	end

	// s2: products
	always_ff @(posedge clk) begin
		if (en) begin
			c_s2 <= c_s1;
			for (int k = 0; k < 3; k++)
				pv_s2[k] <= $signed(rv_s1[k]) * $signed(c_s1.e[k]);
			p1_s2 <= 62'(stiffness) * 62'(g_s1);
			p2_s2 <= 62'(damping) * 62'(g_s1);
		end
	end

	// s3: dot sum, round spring term and damper gain
	always_ff @(posedge clk) begin
		if (en) begin
			c_s3   <= c_s2;
			sum_s3 <= pv_s2[0] + pv_s2[1] + pv_s2[2];
			t1_s3  <= 46'((p1_s2 + 62'd32768) >> 16);
			dg_s3  <= 46'((p2_s2 + 62'd32768) >> 16);
		end
	end

	// s4: normal speed magnitude
	assign smag = sum_s3[63] ? 64'd0 - 64'(sum_s3) : 64'(sum_s3);
	always_ff @(posedge clk) begin
		if (en) begin
			c_s4    <= c_s3;
			t1_s4   <= t1_s3;
			dg_s4   <= dg_s3;
			vneg_s4 <= sum_s3[63];
			vn_s4   <= pbf_pkg::R_W'((smag + 64'h2000_0000) >> 30);
		end
	end

	// s5: damper product as two partial products
	always_ff @(posedge clk) begin
		if (en) begin
			c_s5    <= c_s4;
			t1_s5   <= t1_s4;
			vneg_s5 <= vneg_s4;
			pl_s5   <= 57'(dg_s4[22:0]) * 57'(vn_s4);
			ph_s5   <= 57'(dg_s4[45:23]) * 57'(vn_s4);
		end
	end

	// s6: combine and round damper term, cap on overflow
	assign prod = (80'(ph_s5) << 23) + 80'(pl_s5);
	always_ff @(posedge clk) begin
		if (en) begin
			c_s6    <= c_s5;
			t1_s6   <= t1_s5;
			vneg_s6 <= vneg_s5;
			if (prod[79:64] != '0) begin
				t2_s6  <= 49'h1_0000_0000_0000;
				sat_s6 <= 1'b1;
			end else begin
				t2_s6  <= 49'((prod[63:0] + 64'd32768) >> 16);
				sat_s6 <= 1'b0;
			end
		end
	end

	// s7: force, clip, magnitude, mass choice
	always_comb begin
		if (vneg_s6)
			fac = -$signed({5'b0, t1_s6}) - $signed({2'b0, t2_s6});
		else
			fac = $signed({2'b0, t2_s6}) - $signed({5'b0, t1_s6});
		fac_clip = 1'b0;
		fac_c    = fac;
		if (fac > $signed({4'b0, {pbf_pkg::FAC_W{1'b1}}})) begin
			fac_c    = $signed({4'b0, {pbf_pkg::FAC_W{1'b1}}});
			fac_clip = 1'b1;
		end else if (fac < -$signed({4'b0, {pbf_pkg::FAC_W{1'b1}}})) begin
			fac_c    = -$signed({4'b0, {pbf_pkg::FAC_W{1'b1}}});
			fac_clip = 1'b1;
		end
		fneg = fac_c[50];
		fmag = fneg ? pbf_pkg::FAC_W'(-fac_c) : pbf_pkg::FAC_W'(fac_c);
		msel = (c_s6.kind == pbf_pkg::KIND_BF) ? c_s6.mb : c_s6.ma;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			facmag_o        <= fmag;
			mass_a_o        <= msel;
			mass_b_o        <= c_s6.mb;
			side_o.kind     <= c_s6.kind;
			side_o.fown     <= c_s6.fown;
			side_o.pown     <= c_s6.pown;
			side_o.active   <= c_s6.active;
			side_o.sat      <= sat_s6 | fac_clip;
			side_o.negfac   <= fneg;
			side_o.nega     <= (c_s6.kind == pbf_pkg::KIND_BF) ? fneg : !fneg;
			side_o.fac_zero <= (fmag == '0);
			side_o.ma_zero  <= (msel == '0);
			side_o.mb_zero  <= (c_s6.mb == '0);
			side_o.e        <= c_s6.e;
		end
	end

	assign v_o = v_s[7];
endmodule

/* sv/pbf_div.sv */
// Pipelined restoring divider, one quotient bit per stage, two lanes.
module pbf_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         v_i,
	input  logic [pbf_pkg::FAC_W-1:0]    facmag_i,
	input  logic [pbf_pkg::MASS_W-1:0]   mass_a_i,
	input  logic [pbf_pkg::MASS_W-1:0]   mass_b_i,
	input  pbf_pkg::pbf_side_t           side_i,
	output logic                         v_o,
	output logic [pbf_pkg::DIVD_W-1:0]   qa_o,
	output logic [pbf_pkg::DIVD_W-1:0]   qb_o,
	output pbf_pkg::pbf_side_t           side_o
);
	localparam int N = pbf_pkg::DIVD_W;
	localparam int MW = pbf_pkg::MASS_W;

	logic [N:1]         v_s;
	logic [N-1:0]       dvd_s  [1:N];
	logic [MW-1:0]      rema_s [1:N];
	logic [MW-1:0]      remb_s [1:N];
	logic [N-1:0]       qa_s   [1:N];
	logic [N-1:0]       qb_s   [1:N];
	logic [MW-1:0]      ma_s   [1:N];
	logic [MW-1:0]      mb_s   [1:N];
	pbf_pkg::pbf_side_t side_s [1:N];

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic               vin;
		logic [N-1:0]       dvd, qa, qb;
		logic [MW-1:0]      ra, rb, ma, mb;
		pbf_pkg::pbf_side_t sd;
		logic [MW:0]        ta, tb;
		logic               ga, gb;

		if (i == 0) begin : g_src
			assign vin = v_i;
			assign dvd = {facmag_i, 16'b0};
			assign ra  = '0;
			assign rb  = '0;
			assign qa  = '0;
			assign qb  = '0;
			assign ma  = mass_a_i;
			assign mb  = mass_b_i;
			assign sd  = side_i;
		end else begin : g_prev
			assign vin = v_s[i];
			assign dvd = dvd_s[i];
			assign ra  = rema_s[i];
			assign rb  = remb_s[i];
			assign qa  = qa_s[i];
			assign qb  = qb_s[i];
			assign ma  = ma_s[i];
			assign mb  = mb_s[i];
			assign sd  = side_s[i];
		end

		assign ta = {ra, dvd[N-1]};
		assign tb = {rb, dvd[N-1]};
		assign ga = ta >= {1'b0, ma};
		assign gb = tb >= {1'b0, mb};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i+1] <= 1'b0;
			else if (en)
				v_s[i+1] <= vin;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dvd_s[i+1]  <= {dvd[N-2:0], 1'b0};
				rema_s[i+1] <= ga ? MW'(ta - {1'b0, ma}) : ta[MW-1:0];
				remb_s[i+1] <= gb ? MW'(tb - {1'b0, mb}) : tb[MW-1:0];
				qa_s[i+1]   <= {qa[N-2:0], ga};
				qb_s[i+1]   <= {qb[N-2:0], gb};
				ma_s[i+1]   <= ma;
				mb_s[i+1]   <= mb;
				side_s[i+1] <= sd;
			end
		end
	end

	assign v_o    = v_s[N];
	assign qa_o   = qa_s[N];
	assign qb_o   = qb_s[N];
	assign side_o = side_s[N];
endmodule

/* sv/pbf_scale.sv */
// Scale quotients by direction components, round, saturate, assemble result (2 stages).
module pbf_scale (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         v_i,
	input  logic [pbf_pkg::DIVD_W-1:0]   qa_i,
	input  logic [pbf_pkg::DIVD_W-1:0]   qb_i,
	input  pbf_pkg::pbf_side_t           side_i,
	output logic                         v_o,
	output pbf_pkg::pbf_res_t            res_o
);
	logic                      v_s1, v_s2;
	pbf_pkg::pbf_side_t        side_s1;
	logic [62:0]               ph_s1 [0:1][0:2];
	logic [62:0]               pl_s1 [0:1][0:2];

	logic [pbf_pkg::Q_W-1:0]   qfull [0:1];
	logic [30:0]               em    [0:2];
	logic [pbf_pkg::ACC_W:0]   cres  [0:1][0:2];
	logic [pbf_pkg::R_W-1:0]   rr    [0:1][0:2];
	logic [63:0]               prd   [0:1][0:2];
	logic                      sat_a, sat_b;
	pbf_pkg::pbf_res_t         res_d;

	always_comb begin
		qfull[0] = side_i.fac_zero ? '0 : side_i.ma_zero ? {1'b1, 63'b0} : {1'b0, qa_i};
		qfull[1] = side_i.fac_zero ? '0 : side_i.mb_zero ? {1'b1, 63'b0} : {1'b0, qb_i};
		for (int k = 0; k < 3; k++)
			em[k] = side_i.e[k][31] ? 31'(32'd0 - side_i.e[k]) : side_i.e[k][30:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_i;
			v_s2 <= v_s1;
		end
	end

	// s1: high and low partial products per lane and axis
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_i;
			for (int l = 0; l < 2; l++)
				for (int k = 0; k < 3; k++) begin
					ph_s1[l][k] <= 63'(qfull[l][63:32]) * 63'(em[k]);
					pl_s1[l][k] <= 63'(qfull[l][31:0]) * 63'(em[k]);
				end
		end
	end

	// s2: combine, round, cap, sign and clip
	always_comb begin
		sat_a = 1'b0;
		sat_b = 1'b0;
		for (int l = 0; l < 2; l++)
			for (int k = 0; k < 3; k++) begin
				prd[l][k] = (64'(ph_s1[l][k][29:0]) << 32) + 64'(pl_s1[l][k]);
				if (ph_s1[l][k] >= 63'h4000_0000)
					rr[l][k] = 34'h1_0000_0000;
				else
					rr[l][k] = pbf_pkg::R_W'((prd[l][k] + 64'h2000_0000) >> 30);
				cres[l][k] = pbf_pkg::comp_fn(rr[l][k],
					((l == 0) ? side_s1.nega : side_s1.negfac) ^ side_s1.e[k][31]);
			end
		for (int k = 0; k < 3; k++) begin
			sat_a = sat_a | cres[0][k][pbf_pkg::ACC_W];
			sat_b = sat_b | cres[1][k][pbf_pkg::ACC_W];
		end
	end

	// result assembly: inactive pairs give an all-zero beat
	always_comb begin
		res_d = '0;
		if (side_s1.active) begin
			for (int k = 0; k < 3; k++)
				res_d.acc_a[k] = cres[0][k][pbf_pkg::ACC_W-1:0];
			if (side_s1.kind == pbf_pkg::KIND_FF) begin
				for (int k = 0; k < 3; k++)
					res_d.acc_b[k] = cres[1][k][pbf_pkg::ACC_W-1:0];
				res_d.apply_a = 1'b1;
				res_d.apply_b = side_s1.pown;
				res_d.sat     = side_s1.sat | sat_a | sat_b;
			end else begin
				res_d.apply_a = side_s1.fown;
				res_d.sat     = side_s1.sat | sat_a;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			res_o <= res_d;
	end

	assign v_o = v_s2;
endmodule

/* sv/pair_barrier_force_top.sv */
// Top level of the pair barrier force pipeline.
// Usage:
//  - pair_in carries one neighbour pair per beat (kind, ownership, distance,
//    Q2.30 unit direction, Q16.16 relative velocity, both masses);
//    force_out carries one result beat per pair, in order.
//  - Registers (barrier distance, stiffness, damping) are written through
//    cfg_we/cfg_index/cfg_data; the user must write them only while the
//    pipeline is empty; the block does not enforce it. Throughput: one pair
//    per clock unless force_out stalls. Stages: 7 front (clamp, dot product,
//    spring and damper products, force clip), 63 divider (one quotient bit
//    each, two lanes for both masses), 2 scaling.
//  - The whole pipe moves on one enable: when force_out is stalled with a
//    result waiting, every stage holds and pair_in.ready drops; while the
//    output stage is empty or being drained, a new beat is taken each cycle.
//  - Reset (arst_n low) clears every stage valid bit and restores the
//    register defaults (barrier 1.0, stiffness 1.0, damping 0).
//  - Pairs outside the barrier or of the unused kind give an all-zero beat.
module pair_barrier_force_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pbf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pbf_pkg::CFG_W-1:0]       cfg_data,
	pbf_in_if.sink                          pair_in,
	pbf_out_if.source                       force_out
);
	logic [pbf_pkg::CFG_W-1:0]   barrier_q, stiff_q, damp_q;
	logic                        en;

	// front to divider
	logic                        fv;
	logic [pbf_pkg::FAC_W-1:0]   facmag;
	logic [pbf_pkg::MASS_W-1:0]  mass_a, mass_b;
	pbf_pkg::pbf_side_t          fside;

	// divider to scaler
	logic                        dv;
	logic [pbf_pkg::DIVD_W-1:0]  qa, qb;
	pbf_pkg::pbf_side_t          dside;

	// scaler to port
	logic                        sv;
	pbf_pkg::pbf_res_t           res;

	// configuration registers; out-of-range indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			barrier_q <= pbf_pkg::BARRIER_RST;
			stiff_q   <= pbf_pkg::STIFF_RST;
			damp_q    <= pbf_pkg::DAMP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pbf_pkg::REG_BARRIER: barrier_q <= cfg_data;
				pbf_pkg::REG_STIFF:   stiff_q   <= cfg_data;
				pbf_pkg::REG_DAMP:    damp_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance: output slot free or being taken
	assign en            = !sv || force_out.ready;
	assign pair_in.ready = en;

	pbf_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (en),
		.pair_in          (pair_in),
		.barrier_distance (barrier_q),
		.stiffness        (stiff_q),
		.damping          (damp_q),
		.v_o              (fv),
		.facmag_o         (facmag),
		.mass_a_o         (mass_a),
		.mass_b_o         (mass_b),
		.side_o           (fside)
	);

	pbf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_i      (fv),
		.facmag_i (facmag),
		.mass_a_i (mass_a),
		.mass_b_i (mass_b),
		.side_i   (fside),
		.v_o      (dv),
		.qa_o     (qa),
		.qb_o     (qb),
		.side_o   (dside)
	);

	pbf_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_i    (dv),
		.qa_i   (qa),
		.qb_i   (qb),
		.side_i (dside),
		.v_o    (sv),
		.res_o  (res)
	);

	assign force_out.valid     = sv;
	assign force_out.accel_a_x = res.acc_a[0];
	assign force_out.accel_a_y = res.acc_a[1];
	assign force_out.accel_a_z = res.acc_a[2];
	assign force_out.accel_b_x = res.acc_b[0];
	assign force_out.accel_b_y = res.acc_b[1];
	assign force_out.accel_b_z = res.acc_b[2];
	assign force_out.apply_a   = res.apply_a;
	assign force_out.apply_b   = res.apply_b;
	assign force_out.saturated = res.sat;
endmodule

/* sv/pbf_checker.sv */
// Port-level checker for the pair barrier force top, with its bind.
`include "pair_barrier_force_top_assert.svh"
module pbf_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_ready,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [pbf_pkg::ACC_W-1:0]  accel_a_x,
	input  logic                       apply_a,
	input  logic                       apply_b
);
	// a second-particle increment is only applied on fluid pairs, where the first always is
	`PBF_ASSERT_ALWAYS(a_apply_b_needs_a, !(out_valid && apply_b && !apply_a))
	// an empty output slot never back-pressures the input
	`PBF_ASSERT_ALWAYS(a_ready_when_empty, out_valid || in_ready)
	// a stalled result beat holds
	`PBF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(accel_a_x))
	// input is stalled only while a result waits
	`PBF_ASSERT_ALWAYS(a_stall_only_on_out, in_ready || (out_valid && !out_ready))
endmodule

bind pair_barrier_force_top pbf_checker u_pbf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pair_in.ready),
	.out_valid (force_out.valid),
	.out_ready (force_out.ready),
	.accel_a_x (force_out.accel_a_x),
	.apply_a   (force_out.apply_a),
	.apply_b   (force_out.apply_b)
);

/* bench/pair_barrier_force_top_tb.sv */
// Self-checking testbench of the pair barrier force pipeline.
`timescale 1ns / 1ps

module pair_barrier_force_top_tb;
	// One neighbour pair as driven on pair_in.
	typedef struct {
		logic [1:0]                     kind;
		logic                           fown;
		logic                           pown;
		logic [pbf_pkg::DIST_W-1:0]     distance;
		logic [2:0][pbf_pkg::DIR_W-1:0] dir;
		logic [2:0][pbf_pkg::VEL_W-1:0] relvel;
		logic [pbf_pkg::MASS_W-1:0]     m_first;
		logic [pbf_pkg::MASS_W-1:0]     m_second;
	} pair_t;

	// One force beat as seen on force_out.
	typedef struct {
		logic [2:0][pbf_pkg::ACC_W-1:0] acc_a;
		logic [2:0][pbf_pkg::ACC_W-1:0] acc_b;
		logic                           apply_a;
		logic                           apply_b;
		logic                           sat;
	} force_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [pbf_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [pbf_pkg::CFG_W-1:0] cfg_data;

	pbf_in_if  pair_in();
	pbf_out_if force_out();

	pair_barrier_force_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pair_in   (pair_in),
		.force_out (force_out)
	);

	// Local copy of the three registers.
	logic [63:0] barrier_q, stiff_q, damp_q;

	force_t pending_forces[$];
	int     n_errors;
	int     send_idle_pct, recv_idle_pct;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// ------------------------------------------------------------------
	// Force predictor
	// ------------------------------------------------------------------

	// round(q*|e| / 2^30); huge products capped at 2^32
	function automatic logic [63:0] scale_by_dir(logic [63:0] q, logic [63:0] m);
		logic [63:0] qh, ql, hi;
		qh = q >> 32;
		ql = q & 64'hFFFF_FFFF;
		hi = qh * m;
		if (hi >= 64'd1 << 30)
			return 64'd1 << 32;
		return (((hi << 32) + ql * m) + (64'd1 << 29)) >> 30;
	endfunction

	// Signed component, clipped to 32 bits; sets sat on a clip.
	function automatic logic [31:0] force_comp(logic [63:0] q, longint e, bit neg,
			inout bit sat);
		logic [63:0] r;
		r = scale_by_dir(q, e < 0 ? 64'(-e) : 64'(e));
		if (e < 0)
			neg = !neg;
		if (r == 0)
			return 32'd0;
		if (neg) begin
			if (r > 64'h8000_0000) begin
				r = 64'h8000_0000;
				sat = 1'b1;
			end
			return 32'(64'h1_0000_0000 - r);
		end
		if (r > 64'h7FFF_FFFF) begin
			r = 64'h7FFF_FFFF;
			sat = 1'b1;
		end
		return r[31:0];
	endfunction

	function automatic logic [63:0] accel_quotient(logic [63:0] fmag, logic [63:0] mass);
		if (fmag == 0)
			return 64'd0;
		if (mass == 0)
			return 64'd1 << 63;
		return (fmag << 16) / mass;
	endfunction

	function automatic force_t predict_force(pair_t p);
		force_t       r;
		longint       e[3];
		longint       sum, fac;
		logic [63:0]  smag, vn, g, t1, dg, t2, fmag, qa, qb;
		logic [127:0] wide;
		bit           vneg, sat, negfac, nega;
		r = '{default: '0};
		sat = 1'b0;
		sum = 0;
		if (p.kind == pbf_pkg::KIND_NONE || 64'(p.distance) >= barrier_q)
			return r;
		for (int k = 0; k < 3; k++) begin
			e[k] = longint'($signed(p.dir[k]));
			if (e[k] > 64'sd1073741824)
				e[k] = 64'sd1073741824;
			if (e[k] < -64'sd1073741824)
				e[k] = -64'sd1073741824;
			sum += longint'($signed(p.relvel[k])) * e[k];
		end
		vneg = sum < 0;
		smag = vneg ? 64'(-sum) : 64'(sum);
		vn = (smag + (64'd1 << 29)) >> 30;
		g = barrier_q - 64'(p.distance);
		t1 = (stiff_q * g + 64'd32768) >> 16;
		dg = (damp_q * g + 64'd32768) >> 16;
		wide = {64'd0, dg} * {64'd0, vn};
		if (wide[127:64] != 0) begin
			t2 = 64'd1 << 48;
			sat = 1'b1;
		end else begin
			t2 = wide[63:0] + 64'd32768;   // wraps as a 64-bit sum would
			t2 = t2 >> 16;
			if (t2 > 64'd1 << 48) begin
				t2 = 64'd1 << 48;
				sat = 1'b1;
			end
		end
		fac = vneg ? -longint'(t1) - longint'(t2) : longint'(t2) - longint'(t1);
		if (fac > 64'sd140737488355327) begin
			fac = 64'sd140737488355327;
			sat = 1'b1;
		end
		if (fac < -64'sd140737488355327) begin
			fac = -64'sd140737488355327;
			sat = 1'b1;
		end
		negfac = fac < 0;
		fmag = negfac ? 64'(-fac) : 64'(fac);
		// boundary-first pairs accelerate the fluid (second) particle, with the sign of fac
		if (p.kind == pbf_pkg::KIND_BF) begin
			qa = accel_quotient(fmag, 64'(p.m_second));
			nega = negfac;
		end else begin
			qa = accel_quotient(fmag, 64'(p.m_first));
			nega = !negfac;
		end
		for (int k = 0; k < 3; k++)
			r.acc_a[k] = force_comp(qa, e[k], nega, sat);
		if (p.kind == pbf_pkg::KIND_FF) begin
			qb = accel_quotient(fmag, 64'(p.m_second));
			for (int k = 0; k < 3; k++)
				r.acc_b[k] = force_comp(qb, e[k], negfac, sat);
			r.apply_a = 1'b1;
			r.apply_b = p.pown;
		end else begin
			r.apply_a = p.fown;
			r.apply_b = 1'b0;
		end
		r.sat = sat;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result checker and receiver back-pressure
	// ------------------------------------------------------------------

	always @(negedge clk) begin
		if (!arst_n)
			force_out.ready <= 1'b0;
		else
			force_out.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic int check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v === act_v)
			return 0;
		$display("%0t mismatch %s: expected %h actual %h", $realtime, name, exp_v, act_v);
		return 1;
	endfunction

	always @(posedge clk) begin
		force_t exp_f, act_f;
		int     bad;
		if (arst_n && force_out.valid && force_out.ready) begin
			act_f.acc_a   = {force_out.accel_a_z, force_out.accel_a_y, force_out.accel_a_x};
			act_f.acc_b   = {force_out.accel_b_z, force_out.accel_b_y, force_out.accel_b_x};
			act_f.apply_a = force_out.apply_a;
			act_f.apply_b = force_out.apply_b;
			act_f.sat     = force_out.saturated;
			if (pending_forces.size() == 0) begin
				$display("%0t unexpected force beat: expected none actual %h %h %b%b%b",
					$realtime, act_f.acc_a, act_f.acc_b, act_f.apply_a, act_f.apply_b,
					act_f.sat);
				n_errors++;
			end else begin
				exp_f = pending_forces.pop_front();
				bad = 0;
				bad += check_field("accel_a_x", exp_f.acc_a[0], act_f.acc_a[0]);
				bad += check_field("accel_a_y", exp_f.acc_a[1], act_f.acc_a[1]);
				bad += check_field("accel_a_z", exp_f.acc_a[2], act_f.acc_a[2]);
				bad += check_field("accel_b_x", exp_f.acc_b[0], act_f.acc_b[0]);
				bad += check_field("accel_b_y", exp_f.acc_b[1], act_f.acc_b[1]);
				bad += check_field("accel_b_z", exp_f.acc_b[2], act_f.acc_b[2]);
				bad += check_field("apply_a", 32'(exp_f.apply_a), 32'(act_f.apply_a));
				bad += check_field("apply_b", 32'(exp_f.apply_b), 32'(act_f.apply_b));
				bad += check_field("saturated", 32'(exp_f.sat), 32'(act_f.sat));
				if (bad != 0)
					n_errors++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Driving tasks
	// ------------------------------------------------------------------

	// Sends one pair; valid stays high afterwards so back-to-back beats
	// need no toggle. Each cycle idles with the sender's idle chance.
	// Called at a falling edge, returns at one.
	task automatic send_pair(pair_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			pair_in.valid = 1'b0;
			@(negedge clk);
		end
		pair_in.valid         = 1'b1;
		pair_in.pair_kind     = p.kind;
		pair_in.fluid_owned   = p.fown;
		pair_in.partner_owned = p.pown;
		pair_in.pair_distance = p.distance;
		pair_in.dir_x         = p.dir[0];
		pair_in.dir_y         = p.dir[1];
		pair_in.dir_z         = p.dir[2];
		pair_in.relvel_x      = p.relvel[0];
		pair_in.relvel_y      = p.relvel[1];
		pair_in.relvel_z      = p.relvel[2];
		pair_in.mass_first    = p.m_first;
		pair_in.mass_second   = p.m_second;
		do
			@(posedge clk);
		while (!pair_in.ready);
		pending_forces.push_back(predict_force(p));
		@(negedge clk);
	endtask

	// Lets the pipe empty; the extra wait covers the pipeline depth.
	task automatic drain_pipe();
		pair_in.valid = 1'b0;
		while (pending_forces.size() != 0)
			@(negedge clk);
		repeat (90) @(negedge clk);
	endtask

	task automatic write_reg(logic [pbf_pkg::CFG_IDX_W-1:0] idx,
			logic [pbf_pkg::CFG_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			pbf_pkg::REG_BARRIER: barrier_q = 64'(val);
			pbf_pkg::REG_STIFF:   stiff_q   = 64'(val);
			pbf_pkg::REG_DAMP:    damp_q    = 64'(val);
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [pbf_pkg::CFG_W-1:0] bar, logic [pbf_pkg::CFG_W-1:0] stf,
			logic [pbf_pkg::CFG_W-1:0] dmp);
		drain_pipe();
		write_reg(pbf_pkg::REG_BARRIER, bar);
		write_reg(pbf_pkg::REG_STIFF, stf);
		write_reg(pbf_pkg::REG_DAMP, dmp);
	endtask

	// ------------------------------------------------------------------
	// Random content
	// ------------------------------------------------------------------

	function automatic logic [31:0] rand_dir();
		case ($urandom_range(3))
			0: return $urandom();                     // anything, clamp exercised
			1: return $urandom_range(1) ? pbf_pkg::ONE_Q30 : pbf_pkg::MINUS_ONE_Q30;
			default: return 32'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000;
		endcase
	endfunction

	function automatic logic [31:0] rand_vel();
		case ($urandom_range(2))
			0: return $urandom();
			1: return 32'($signed(32'($urandom_range(0, 32'h0020_0000))) - 32'sh0010_0000);
			default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		endcase
	endfunction

	function automatic logic [pbf_pkg::MASS_W-1:0] rand_mass();
		logic [pbf_pkg::MASS_W-1:0] m;
		case ($urandom_range(2))
			0: m = 31'($urandom_range(1, 32'h0010_0000));
			1: m = 31'($urandom());
			default: m = 31'($urandom()) >> $urandom_range(30);
		endcase
		return (m == 0) ? 31'd1 : m;
	endfunction

	function automatic pair_t rand_pair();
		pair_t p;
		int    roll;
		roll = $urandom_range(99);
		p.kind = (roll < 3) ? pbf_pkg::KIND_NONE : 2'($urandom_range(2));
		p.fown = $urandom_range(1);
		p.pown = $urandom_range(1);
		// mostly inside the barrier so the force path is reached
		if (roll < 80)
			p.distance = 31'(64'($urandom()) % barrier_q);
		else
			p.distance = 31'($urandom());
		for (int k = 0; k < 3; k++) begin
			p.dir[k]    = rand_dir();
			p.relvel[k] = rand_vel();
		end
		p.m_first  = rand_mass();
		p.m_second = rand_mass();
		return p;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Edge cases: every kind, barrier edges, clamp, extreme speeds and masses.
	task automatic test_directed();
		pair_t p;
		set_regs(31'h0004_0000, 31'h0001_0000, 31'h0000_8000);
		for (int i = 0; i < 24; i++) begin
			p = rand_pair();
			p.kind = 2'(i % 4);
			p.fown = i[2];
			p.pown = i[3];
			case (i % 6)
				0: p.distance = 31'd0;
				1: p.distance = 31'(barrier_q - 1);
				2: p.distance = 31'(barrier_q);                // just outside
				3: p.distance = 31'h7FFF_FFFF;
				default: p.distance = 31'h0000_8000;
			endcase
			case (i % 5)
				0: p.dir = {32'h7FFF_FFFF, 32'h8000_0000, 32'd0};
				1: p.dir = {pbf_pkg::ONE_Q30, pbf_pkg::MINUS_ONE_Q30, pbf_pkg::ONE_Q30};
				2: p.dir = {32'd0, 32'd0, 32'd0};
				default: ;
			endcase
			if (i % 3 == 0)
				p.relvel = {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
			if (i % 4 == 1) begin
				p.m_first  = 31'd1;
				p.m_second = 31'h7FFF_FFFF;
			end else if (i % 4 == 2) begin
				p.m_first  = 31'h7FFF_FFFF;
				p.m_second = 31'd1;
			end
			send_pair(p);
		end
		// strongest barrier, heaviest damping: forces clip everywhere
		set_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
		for (int i = 0; i < 6; i++) begin
			p = rand_pair();
			p.kind = 2'(i % 3);
			p.distance = 31'd0;
			p.relvel = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
			p.dir = {pbf_pkg::ONE_Q30, pbf_pkg::ONE_Q30, pbf_pkg::ONE_Q30};
			p.m_first = 31'd1;
			p.m_second = 31'd1;
			send_pair(p);
		end
	endtask

	task automatic test_random(int n_pairs, logic [pbf_pkg::CFG_W-1:0] bar,
			logic [pbf_pkg::CFG_W-1:0] stf, logic [pbf_pkg::CFG_W-1:0] dmp,
			int s_idle, int r_idle);
		set_regs(bar, stf, dmp);
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		for (int i = 0; i < n_pairs; i++)
			send_pair(rand_pair());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = pbf_pkg::REG_BARRIER;
		cfg_data = '0;
		pair_in.valid = 1'b0;
		pair_in.pair_kind = pbf_pkg::KIND_FF;
		pair_in.fluid_owned = 1'b0;
		pair_in.partner_owned = 1'b0;
		pair_in.pair_distance = '0;
		pair_in.dir_x = '0;
		pair_in.dir_y = '0;
		pair_in.dir_z = '0;
		pair_in.relvel_x = '0;
		pair_in.relvel_y = '0;
		pair_in.relvel_z = '0;
		pair_in.mass_first = 31'd1;
		pair_in.mass_second = 31'd1;
		force_out.ready = 1'b0;
		barrier_q = 64'(pbf_pkg::BARRIER_RST);
		stiff_q = 64'(pbf_pkg::STIFF_RST);
		damp_q = 64'(pbf_pkg::DAMP_RST);
		n_errors = 0;
		send_idle_pct = 13;
		recv_idle_pct = 62;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// a few pairs against the reset registers first
		for (int i = 0; i < 10; i++)
			send_pair(rand_pair());
		test_directed();
		// sender sparse gaps, receiver mostly stalled
		test_random(250, 31'h0001_0000, 31'h0001_0000, 31'd0, 13, 62);
		test_random(250, 31'h0080_0000, 31'h0100_0000, 31'h0002_0000, 13, 62);
		// roles swapped
		test_random(250, 31'd1, 31'd1, 31'h7FFF_FFFF, 62, 13);
		test_random(250, 31'h7FFF_FFFF, 31'h0000_4000, 31'h0000_0100, 62, 13);
		// full rate both sides
		test_random(250, 31'h0010_0000, 31'h7FFF_FFFF, 31'h0001_0000, 0, 0);
		test_random(250, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 0);

		drain_pipe();
		if (n_errors == 0)
			$display("PASS pair_barrier_force_top");
		else
			$display("FAIL pair_barrier_force_top");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#50ms;
		$display("FAIL pair_barrier_force_top");
		$finish;
	end
endmodule

/* filelist.f */
+incdir+sv
sv/pbf_pkg.sv
sv/pbf_ifs.sv
sv/pbf_front.sv
sv/pbf_div.sv
sv/pbf_scale.sv
sv/pair_barrier_force_top.sv
sv/pbf_checker.sv
bench/pair_barrier_force_top_tb.sv
